// ===== rtl/core/sppq_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sppq_pkg
// Shared types and constants of the sorted point priority queue: operation,
// compare mode and status codes, and the command and status words that run
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package sppq_pkg;

  // Default sizes of the queue.
  localparam int unsigned CapacityDef   = 16;
  localparam int unsigned CoordWidthDef = 16;

  // Fixed field widths of the interface.
  localparam int unsigned ModeW   = 2;
  localparam int unsigned StatusW = 2;
  localparam int unsigned OccW    = 5;

  // Operation codes.
  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_POP  = 1'b1;

  // Compare modes. The unused code orders like x then y.
  localparam logic [ModeW-1:0] MODE_XY  = 2'd0;
  localparam logic [ModeW-1:0] MODE_YX  = 2'd1;
  localparam logic [ModeW-1:0] MODE_MAG = 2'd2;

  // Result status codes.
  localparam logic [StatusW-1:0] STAT_OK    = 2'd0;
  localparam logic [StatusW-1:0] STAT_EMPTY = 2'd1;
  localparam logic [StatusW-1:0] STAT_FULL  = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // register the incoming word
    logic square;   // register the squares of the new point
    logic sum;      // register the squared magnitude
    logic commit;   // update the cells and load the result register
  } sppq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_pop;   // the word on the input is a pop
  } sppq_stat_t;

endpackage
`default_nettype wire

// ===== rtl/core/sppq_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sppq_ctrl
// Controller of the priority queue: sequences a push through the squaring,
// sum and update steps, sends a pop straight to the update, and owns the
// valid of the result register.
// ----------------------------------------------------------------------------
module sppq_ctrl
  import sppq_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  input  wire sppq_stat_t stat_i,
  output sppq_cmd_t       cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SQUARE = 4'b0010,
    ST_SUM    = 4'b0100,
    ST_UPDATE = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;
  logic   out_free;

  // A new word is taken only while idle.
  assign in_stall_o  = (state_q != ST_IDLE);
  assign accept      = in_valid_i && (state_q == ST_IDLE);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;

  // Next state and commands.
  always_comb begin
    state_d        = state_q;
    cmd_o.capture  = 1'b0;
    cmd_o.square   = 1'b0;
    cmd_o.sum      = 1'b0;
    cmd_o.commit   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.capture = 1'b1;
          state_d       = stat_i.is_pop ? ST_UPDATE : ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        cmd_o.square = 1'b1;
        state_d      = ST_SUM;
      end
      ST_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = ST_UPDATE;
      end
      ST_UPDATE: begin
        // Wait until the result register can take the new word.
        if (out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Result valid: set by a commit, cleared when the word is taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/sppq_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sppq_dp
// Datapath of the priority queue: the compare mode register, the row of
// sorted cells with their squared magnitudes, the fill count, the squaring
// pipeline of the new point and the result register.
// ----------------------------------------------------------------------------
module sppq_dp
  import sppq_pkg::*;
#(
  parameter int unsigned CAPACITY    = CapacityDef,
  parameter int unsigned COORD_WIDTH = CoordWidthDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [ModeW-1:0]              cfg_wdata_i,
  input  wire logic                          func_i,
  input  wire logic signed [COORD_WIDTH-1:0] point_x_i,
  input  wire logic signed [COORD_WIDTH-1:0] point_y_i,
  input  wire sppq_cmd_t                     cmd_i,
  output sppq_stat_t                         stat_o,
  output logic signed [COORD_WIDTH-1:0]      head_x_o,
  output logic signed [COORD_WIDTH-1:0]      head_y_o,
  output logic [StatusW-1:0]                 status_o,
  output logic [OccW-1:0]                    occupancy_out_o,
  output logic                               empty_flag_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned MagW = 2 * COORD_WIDTH;

  // Strict order of point a below point b under the given mode.
  function automatic logic is_lower(
    input logic [ModeW-1:0]              mode,
    input logic signed [COORD_WIDTH-1:0] ax,
    input logic signed [COORD_WIDTH-1:0] ay,
    input logic [MagW-1:0]               am,
    input logic signed [COORD_WIDTH-1:0] bx,
    input logic signed [COORD_WIDTH-1:0] by,
    input logic [MagW-1:0]               bm
  );
    logic res;
    unique case (mode)
      MODE_MAG: res = (am < bm);
      MODE_YX:  res = (ay != by) ? (ay < by) : (ax < bx);
      default:  res = (ax != bx) ? (ax < bx) : (ay < by);
    endcase
    return res;
  endfunction

  logic [ModeW-1:0]              mode_q;
  logic [CntW-1:0]               count_q, count_d;
  logic                          func_q;
  logic signed [COORD_WIDTH-1:0] px_q, py_q;
  logic signed [MagW-1:0]        sq_x, sq_y;
  logic [MagW-1:0]               sqx_q, sqy_q, mag_q;

  logic signed [COORD_WIDTH-1:0] cell_x_q [CAPACITY];
  logic signed [COORD_WIDTH-1:0] cell_y_q [CAPACITY];
  logic [MagW-1:0]               cell_m_q [CAPACITY];

  logic [CAPACITY-1:0]           stop;
  logic [CAPACITY-1:0]           take_prev;
  logic                          no_entries, is_full, push_go, pop_go;

  logic signed [COORD_WIDTH-1:0] head_x_d, head_y_d, head_x_q, head_y_q;
  logic [StatusW-1:0]            status_d, status_q;
  logic [CntW-1:0]               occ_q;

  assign stat_o.is_pop = (func_i == FUNC_POP);

  // Compare mode register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_XY;
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i;
    end
  end

  // Input capture, squares and squared magnitude of the new point.
  assign sq_x = MagW'(px_q) * MagW'(px_q);
  assign sq_y = MagW'(py_q) * MagW'(py_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q <= func_i;
      px_q   <= point_x_i;
      py_q   <= point_y_i;
    end
    if (cmd_i.square) begin
      sqx_q <= MagW'(sq_x);
      sqy_q <= MagW'(sq_y);
    end
    if (cmd_i.sum) begin
      mag_q <= sqx_q + sqy_q;
    end
  end

  assign no_entries = (count_q == '0);
  assign is_full    = (count_q == CntW'(CAPACITY));
  assign push_go    = cmd_i.commit && (func_q == FUNC_PUSH) && !is_full;
  assign pop_go     = cmd_i.commit && (func_q == FUNC_POP) && !no_entries;

  // The row of cells. A cell stops the search when it is unused or orders
  // below the new point; the first stopping cell takes the new point and
  // every cell after it takes its upper neighbor.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam int unsigned Prv = (i == 0) ? 0 : i - 1;
    localparam int unsigned Nxt = (i == CAPACITY - 1) ? i : i + 1;

    assign stop[i] = (CntW'(i) >= count_q) ||
                     is_lower(mode_q, cell_x_q[i], cell_y_q[i], cell_m_q[i],
                              px_q, py_q, mag_q);

    if (i == 0) begin : g_first
      assign take_prev[i] = 1'b0;
    end else begin : g_rest
      assign take_prev[i] = |stop[i-1:0];
    end

    always_ff @(posedge clk_i) begin
      if (pop_go) begin
        cell_x_q[i] <= cell_x_q[Nxt];
        cell_y_q[i] <= cell_y_q[Nxt];
        cell_m_q[i] <= cell_m_q[Nxt];
      end else if (push_go) begin
        if (take_prev[i]) begin
          cell_x_q[i] <= cell_x_q[Prv];
          cell_y_q[i] <= cell_y_q[Prv];
          cell_m_q[i] <= cell_m_q[Prv];
        end else if (stop[i]) begin
          cell_x_q[i] <= px_q;
          cell_y_q[i] <= py_q;
          cell_m_q[i] <= mag_q;
        end
      end
    end
  end

  // Next fill count, result head and status.
  always_comb begin
    count_d  = count_q;
    status_d = STAT_OK;
    head_x_d = cell_x_q[0];
    head_y_d = cell_y_q[0];
    if (func_q == FUNC_POP) begin
      if (no_entries) begin
        status_d = STAT_EMPTY;
        head_x_d = '0;
        head_y_d = '0;
      end else begin
        count_d = count_q - 1'b1;
      end
    end else if (is_full) begin
      status_d = STAT_FULL;
    end else begin
      count_d = count_q + 1'b1;
      if (stop[0]) begin
        head_x_d = px_q;
        head_y_d = py_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.commit) begin
      count_q <= count_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      head_x_q <= head_x_d;
      head_y_q <= head_y_d;
      status_q <= status_d;
      occ_q    <= count_d;
    end
  end

  assign head_x_o        = head_x_q;
  assign head_y_o        = head_y_q;
  assign status_o        = status_q;
  assign occupancy_out_o = OccW'(occ_q);
  assign empty_flag_o    = (occ_q == '0);

endmodule
`default_nettype wire

// ===== rtl/core/sorted_point_priority_queue_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_point_priority_queue_top
// Bounded priority queue of signed 2-D points kept in sorted order, with
// the greatest point at the head and equal points leaving in arrival order.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o) carries one word: func_i selects a
// push of point_x_i/point_y_i or a pop of the head. The output channel
// (out_valid_o / out_stall_i) returns one word per input word: the popped or
// current head, a status, the occupancy and an empty flag.
// The compare mode (x then y, y then x, or squared magnitude) is set through
// cfg_we_i / cfg_wdata_i. The user must write it only while the queue is
// idle; the block itself does not enforce this. A push passes the squaring
// multiplier, the magnitude adder, and the parallel compare and cell shift,
// each registered; a pop goes straight to the compare and cell shift. One
// word is in flight at a time; the next word is taken while the previous
// result still waits in the output register.
// When the receiver stalls, the result holds and the next word stops in the
// update step until the output register frees up.
// Reset empties the queue and sets the compare mode to x then y; the cells
// need no clearing since only filled cells are read.
// ----------------------------------------------------------------------------
module sorted_point_priority_queue_top
  import sppq_pkg::*;
#(
  parameter int unsigned CAPACITY    = CapacityDef,
  parameter int unsigned COORD_WIDTH = CoordWidthDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [ModeW-1:0]              cfg_wdata_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic                          func_i,
  input  wire logic signed [COORD_WIDTH-1:0] point_x_i,
  input  wire logic signed [COORD_WIDTH-1:0] point_y_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic signed [COORD_WIDTH-1:0]      head_x_o,
  output logic signed [COORD_WIDTH-1:0]      head_y_o,
  output logic [StatusW-1:0]                 status_o,
  output logic [OccW-1:0]                    occupancy_out_o,
  output logic                               empty_flag_o
);

  sppq_cmd_t  cmd;
  sppq_stat_t stat;

  // Sequencing of each word.
  sppq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Cells, compare logic and result register.
  sppq_dp #(
    .CAPACITY    (CAPACITY),
    .COORD_WIDTH (COORD_WIDTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .func_i          (func_i),
    .point_x_i       (point_x_i),
    .point_y_i       (point_y_i),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .head_x_o        (head_x_o),
    .head_y_o        (head_y_o),
    .status_o        (status_o),
    .occupancy_out_o (occupancy_out_o),
    .empty_flag_o    (empty_flag_o)
  );

endmodule
`default_nettype wire

// ===== rtl/core/sppq_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sppq_checker
// Port-level checks of the priority queue, bound to the top level.
// ----------------------------------------------------------------------------
module sppq_checker
  import sppq_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = CoordWidthDef
) (
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   in_valid_i,
  input wire logic                   in_stall_o,
  input wire logic                   out_valid_o,
  input wire logic                   out_stall_i,
  input wire logic [COORD_WIDTH-1:0] head_x_o,
  input wire logic [COORD_WIDTH-1:0] head_y_o,
  input wire logic [StatusW-1:0]     status_o,
  input wire logic [OccW-1:0]        occupancy_out_o,
  input wire logic                   empty_flag_o
);

  // One word in flight: an accepted word blocks the input on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken again right after an accepted word");

  // A new result only shows up while a word was in work.
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared with no word in work");

  // A pop on an empty queue leaves it empty and reports a zero head.
  a_empty_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == STAT_EMPTY)) |->
      (empty_flag_o && (occupancy_out_o == '0) && (head_x_o == '0) &&
       (head_y_o == '0)))
    else $error("pop on empty queue reported a point or a count");

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(head_x_o) && $stable(head_y_o) &&
       $stable(status_o) && $stable(occupancy_out_o)))
    else $error("stalled result word changed");

endmodule

bind sorted_point_priority_queue_top sppq_checker #(
  .COORD_WIDTH (COORD_WIDTH)
) u_sppq_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .head_x_o        (head_x_o),
  .head_y_o        (head_y_o),
  .status_o        (status_o),
  .occupancy_out_o (occupancy_out_o),
  .empty_flag_o    (empty_flag_o)
);
`default_nettype wire

// ===== tb/sppq_order_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sppq_order_checker
// Watches the configuration port and both channels of the sorted point
// priority queue. Each accepted input word is run through a private copy of
// the queue to work out the result word it must produce, and each accepted
// result word is compared field by field with the oldest outstanding one.
// ----------------------------------------------------------------------------
module sppq_order_checker
  import sppq_pkg::*;
#(
  parameter int unsigned CAPACITY    = CapacityDef,
  parameter int unsigned COORD_WIDTH = CoordWidthDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [ModeW-1:0]              cfg_wdata_i,
  input  wire logic                          in_valid_i,
  input  wire logic                          in_stall_i,
  input  wire logic                          func_i,
  input  wire logic signed [COORD_WIDTH-1:0] point_x_i,
  input  wire logic signed [COORD_WIDTH-1:0] point_y_i,
  input  wire logic                          out_valid_i,
  input  wire logic                          out_stall_i,
  input  wire logic signed [COORD_WIDTH-1:0] head_x_i,
  input  wire logic signed [COORD_WIDTH-1:0] head_y_i,
  input  wire logic [StatusW-1:0]            status_i,
  input  wire logic [OccW-1:0]               occupancy_i,
  input  wire logic                          empty_flag_i,
  output int unsigned                        mismatches_o,
  output int unsigned                        in_flight_o
);

  // One result word as the queue must return it.
  typedef struct {
    logic [COORD_WIDTH-1:0] head_x;
    logic [COORD_WIDTH-1:0] head_y;
    logic [StatusW-1:0]     status;
    logic [OccW-1:0]        occupancy;
    logic                   empty;
  } head_word_t;

  // Private copy of the queue: cell 0 is the head.
  logic [ModeW-1:0]              order_mode;
  logic signed [COORD_WIDTH-1:0] cell_x [CAPACITY];
  logic signed [COORD_WIDTH-1:0] cell_y [CAPACITY];
  int unsigned                   stored;

  head_word_t  awaited_heads[$];
  head_word_t  want;
  int unsigned results_seen;
  int unsigned fault_count;

  // Exact squared distance from the origin.
  function automatic longint squared_norm(logic signed [COORD_WIDTH-1:0] x,
                                          logic signed [COORD_WIDTH-1:0] y);
    longint sx;
    longint sy;
    sx = x;
    sy = y;
    return sx * sx + sy * sy;
  endfunction

  // True when point a orders strictly below point b in the current mode.
  function automatic bit ranks_below(logic signed [COORD_WIDTH-1:0] ax,
                                     logic signed [COORD_WIDTH-1:0] ay,
                                     logic signed [COORD_WIDTH-1:0] bx,
                                     logic signed [COORD_WIDTH-1:0] by);
    case (order_mode)
      MODE_MAG: return squared_norm(ax, ay) < squared_norm(bx, by);
      MODE_YX: begin
        if (ay != by) return ay < by;
        return ax < bx;
      end
      // The spare code orders like x then y.
      default: begin
        if (ax != bx) return ax < bx;
        return ay < by;
      end
    endcase
  endfunction

  // Apply one push or pop to the private queue and return its result word.
  function automatic head_word_t apply_queue_op(logic op,
                                                logic signed [COORD_WIDTH-1:0] px,
                                                logic signed [COORD_WIDTH-1:0] py);
    head_word_t  res;
    int unsigned pos;
    int unsigned i;
    res.head_x = '0;
    res.head_y = '0;
    res.status = STAT_OK;
    if (op == FUNC_POP) begin
      if (stored == 0) begin
        res.status = STAT_EMPTY;
      end else begin
        res.head_x = cell_x[0];
        res.head_y = cell_y[0];
        for (i = 1; i < stored; i++) begin
          cell_x[i-1] = cell_x[i];
          cell_y[i-1] = cell_y[i];
        end
        stored--;
      end
    end else if (stored >= CAPACITY) begin
      res.status = STAT_FULL;
    end else begin
      // The new point goes just ahead of the first cell that ranks below it.
      pos = 0;
      while (pos < stored && !ranks_below(cell_x[pos], cell_y[pos], px, py)) pos++;
      for (i = stored; i > pos; i--) begin
        cell_x[i] = cell_x[i-1];
        cell_y[i] = cell_y[i-1];
      end
      cell_x[pos] = px;
      cell_y[pos] = py;
      stored++;
    end
    // Everything but a pop reports the head as it stands afterwards.
    if (op != FUNC_POP && stored > 0) begin
      res.head_x = cell_x[0];
      res.head_y = cell_y[0];
    end
    res.occupancy = stored[OccW-1:0];
    res.empty     = (stored == 0);
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint exp_val);
    $display("[sppq_checker] result %0d: %s is %0d, expected %0d",
             results_seen, what, got, exp_val);
    fault_count++;
  endtask

  // Follow the register writes and both channels at every clock edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_mode = MODE_XY;
      stored     = 0;
      awaited_heads.delete();
      in_flight_o <= 0;
    end else begin
      if (cfg_we_i) order_mode = cfg_wdata_i;
      if (out_valid_i && !out_stall_i) begin
        results_seen++;
        if (awaited_heads.size() == 0) begin
          report_mismatch("word with none outstanding, status", status_i, 0);
        end else begin
          want = awaited_heads[0];
          awaited_heads.delete(0);
          if (head_x_i !== want.head_x)
            report_mismatch("head_x", head_x_i, $signed(want.head_x));
          if (head_y_i !== want.head_y)
            report_mismatch("head_y", head_y_i, $signed(want.head_y));
          if (status_i !== want.status)
            report_mismatch("status", status_i, want.status);
          if (occupancy_i !== want.occupancy)
            report_mismatch("occupancy", occupancy_i, want.occupancy);
          if (empty_flag_i !== want.empty)
            report_mismatch("empty_flag", empty_flag_i, want.empty);
        end
      end
      if (in_valid_i && !in_stall_i)
        awaited_heads.push_back(apply_queue_op(func_i, point_x_i, point_y_i));
      in_flight_o  <= awaited_heads.size();
      mismatches_o <= fault_count;
    end
  end

endmodule

// ===== tb/tb_sorted_point_priority_queue_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_point_priority_queue_top
// Stimulus and verdict for the sorted point priority queue. A short directed
// run covers empty pops, extreme coordinates and ties under x then y and
// squared magnitude; then random phases fill, churn and drain the queue under
// each compare mode with random gaps on the input and random stalls on the
// output. Checking is done by the order checker instantiated beside the block.
// ----------------------------------------------------------------------------
module tb_sorted_point_priority_queue_top
  import sppq_pkg::*;
;

  localparam int unsigned CW   = CoordWidthDef;
  localparam int unsigned CAP  = CapacityDef;
  localparam logic [ModeW-1:0] MODE_SPARE = 2'd3;

  logic                  clk         = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we      = 1'b0;
  logic [ModeW-1:0]      cfg_wdata   = '0;
  logic                  in_valid    = 1'b0;
  logic                  func        = FUNC_PUSH;
  logic signed [CW-1:0]  point_x     = '0;
  logic signed [CW-1:0]  point_y     = '0;
  logic                  out_stall   = 1'b0;
  logic                  in_stall_o;
  logic                  out_valid_o;
  logic signed [CW-1:0]  head_x_o;
  logic signed [CW-1:0]  head_y_o;
  logic [StatusW-1:0]    status_o;
  logic [OccW-1:0]       occupancy_out_o;
  logic                  empty_flag_o;
  int unsigned           mismatches;
  int unsigned           in_flight;

  // Rough fill level kept by the stimulus to steer toward full and empty.
  int unsigned fill;
  // No idling on either side while set.
  bit          rush;

  sorted_point_priority_queue_top #(
    .CAPACITY   (CAP),
    .COORD_WIDTH(CW)
  ) dut (
    .clk_i          (clk),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall_o),
    .func_i         (func),
    .point_x_i      (point_x),
    .point_y_i      (point_y),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall),
    .head_x_o       (head_x_o),
    .head_y_o       (head_y_o),
    .status_o       (status_o),
    .occupancy_out_o(occupancy_out_o),
    .empty_flag_o   (empty_flag_o)
  );

  sppq_order_checker #(
    .CAPACITY   (CAP),
    .COORD_WIDTH(CW)
  ) order_checker (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall_o),
    .func_i      (func),
    .point_x_i   (point_x),
    .point_y_i   (point_y),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall),
    .head_x_i    (head_x_o),
    .head_y_i    (head_y_o),
    .status_i    (status_o),
    .occupancy_i (occupancy_out_o),
    .empty_flag_i(empty_flag_o),
    .mismatches_o(mismatches),
    .in_flight_o (in_flight)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Wait cycles before a word or after a result: mostly short, sometimes long.
  function automatic int unsigned pick_wait();
    if (rush) return 0;
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return $urandom_range(0, 3);
      default: return $urandom_range(0, 17);
    endcase
  endfunction

  // Coordinates mix full-range values, tight clusters that tie, and extremes.
  function automatic logic [CW-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0, 1: return CW'($urandom);
      2, 3: return CW'($urandom_range(0, 6) - 3);
      4: begin
        case ($urandom_range(0, 3))
          0:       return 16'h7fff;
          1:       return 16'h8000;
          2:       return 16'h0000;
          default: return 16'hffff;
        endcase
      end
      default: return CW'($urandom_range(0, 200) - 100);
    endcase
  endfunction

  // Offer one word after a random gap and return at the edge it is taken.
  task automatic send_word(input logic op, input logic [CW-1:0] x,
                           input logic [CW-1:0] y);
    int unsigned gap;
    gap = pick_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    func     <= op;
    point_x  <= x;
    point_y  <= y;
    do @(posedge clk); while (in_stall_o);
    if (op == FUNC_POP) begin
      if (fill > 0) fill--;
    end else if (fill < CAP) begin
      fill++;
    end
  endtask

  task automatic push_point(input logic [CW-1:0] x, input logic [CW-1:0] y);
    send_word(FUNC_PUSH, x, y);
  endtask

  // Pop words carry random coordinates that the block must ignore.
  task automatic pop_head();
    send_word(FUNC_POP, rand_coord(), rand_coord());
  endtask

  // Hold the input until every outstanding result has been taken.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (in_flight != 0) @(posedge clk);
  endtask

  task automatic set_order(input logic [ModeW-1:0] mode);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= mode;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Output side: stall for a random count after each taken result, and now
  // and then while nothing is offered.
  initial begin
    int unsigned hold;
    hold = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
        if (hold == 0) out_stall <= 1'b0;
      end else if ((out_valid_o && !out_stall) ||
                   (!out_valid_o && $urandom_range(0, 15) == 0)) begin
        hold = pick_wait();
        if (hold > 0) out_stall <= 1'b1;
      end
    end
  end

  // Stimulus and verdict.
  initial begin
    int unsigned      push_pct;
    int unsigned      n;
    logic [ModeW-1:0] mode;
    fill = 0;
    rush = 1'b0;
    repeat (4) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    // Directed, x then y after reset: empty pop, extremes, then drain past empty.
    pop_head();
    push_point(16'h0000, 16'h0000);
    push_point(16'h7fff, 16'h8000);
    push_point(16'h8000, 16'h7fff);
    push_point(16'h7fff, 16'h7fff);
    push_point(16'h8000, 16'h8000);
    push_point(16'hffff, 16'hffff);
    repeat (7) pop_head();

    // Directed, squared magnitude: equal norms must leave in arrival order.
    set_order(MODE_MAG);
    push_point(16'd3, 16'd4);
    push_point(-16'sd4, 16'd3);
    push_point(16'd5, 16'd0);
    push_point(16'h8000, 16'h8000);
    push_point(16'd0, -16'sd5);
    push_point(16'h7fff, 16'h8000);
    repeat (6) pop_head();

    // Random phases under every mode; most start from an empty queue.
    for (int phase = 0; phase < 12; phase++) begin
      if (phase % 4 != 3) begin
        while (fill > 0) pop_head();
      end
      case (phase)
        0:       mode = MODE_YX;
        1:       mode = MODE_SPARE;
        2:       mode = MODE_MAG;
        3:       mode = MODE_XY;
        default: mode = ModeW'($urandom_range(0, 3));
      endcase
      set_order(mode);
      rush = ($urandom_range(0, 3) == 0);
      if (phase == 0) begin
        // Fill to capacity and keep pushing to hit the full case.
        while (fill < CAP) push_point(rand_coord(), rand_coord());
        repeat (2) push_point(rand_coord(), rand_coord());
      end else begin
        case (phase % 3)
          0:       push_pct = 85;
          1:       push_pct = 50;
          default: push_pct = 30;
        endcase
        for (n = 0; n < 32; n++) begin
          if ($urandom_range(0, 99) < push_pct) push_point(rand_coord(), rand_coord());
          else pop_head();
        end
      end
      rush = 1'b0;
    end

    settle();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && in_flight == 0) begin
      $display("[sorted_point_priority_queue_top] OK");
    end else begin
      $display("[sorted_point_priority_queue_top] ERROR");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #5000000;
    $display("[sorted_point_priority_queue_top] ERROR");
    $finish;
  end

endmodule
